FILE: hw/rtl/randomized_blink_envelope_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// Blink sequencer assertion macros
// Shared property wrappers, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_BLINK_ENVELOPE_SEQUENCER_CORE_DEFINES_SVH
`define RANDOMIZED_BLINK_ENVELOPE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define RBES_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBES_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rbes_pkg.sv
// ----------------------------------------------------------------------------
// Blink sequencer package
// Timing constants, ramp tables, payload types and microcode definitions.
// ----------------------------------------------------------------------------
package rbes_pkg;

  localparam int unsigned STEP_TICKS   = 20;
  localparam int unsigned CLOSE_TICKS  = 80;
  localparam int unsigned HOLD_TICKS   = 30;
  localparam int unsigned OPEN_TICKS   = 120;

  localparam int unsigned CLOSE_TARGET = 210;
  localparam int unsigned CLOSED_LEVEL = 256;

  localparam int unsigned CLOSE_STEPS = CLOSE_TICKS / STEP_TICKS;
  localparam int unsigned OPEN_STEPS  = OPEN_TICKS / STEP_TICKS;
  localparam int unsigned MAX_STEPS   = (CLOSE_STEPS > OPEN_STEPS) ? CLOSE_STEPS : OPEN_STEPS;
  localparam int unsigned STEP_W      = (MAX_STEPS < 1) ? 1 : $clog2(MAX_STEPS + 1);
  localparam int unsigned MAX_TICKS   = (STEP_TICKS > HOLD_TICKS) ? STEP_TICKS : HOLD_TICKS;
  localparam int unsigned TICK_W      = $clog2(MAX_TICKS + 1);
  localparam int unsigned TAB_DEPTH   = 2 ** STEP_W;

  typedef logic [8:0]        level_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [12:0]       ival_t;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_CLOSE = 2'd1,
    PH_HOLD  = 2'd2,
    PH_OPEN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_SUP_ON  = 2'd2,
    CMD_SUP_OFF = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ENERGY  = 2'd0,
    CFG_MIN_IVL = 2'd1,
    CFG_MAX_IVL = 2'd2,
    CFG_BIAS    = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] random_word;
  } in_item_t;

  typedef struct packed {
    level_t     blink_level;
    logic       level_changed;
    logic [1:0] phase;
  } out_item_t;

  // sequencer state carried between items
  typedef struct packed {
    phase_t phase;
    ival_t  wait_count;
    ival_t  wait_target;
    logic   need_draw;
    tick_t  tick;
    step_t  step;
    logic   pend;
    logic   sup;
    level_t level;
  } blk_t;

  // ramp tables, entries past the last step are unused
  typedef level_t ramp_tab_t [TAB_DEPTH];

  function automatic ramp_tab_t close_tab_f();
    ramp_tab_t t;
    for (int unsigned i = 0; i < TAB_DEPTH; i++) begin
      t[i] = '0;
      if (i >= 1 && i <= CLOSE_STEPS) begin
        t[i] = level_t'((CLOSE_TARGET * i + CLOSE_STEPS / 2) / CLOSE_STEPS);
      end
    end
    return t;
  endfunction

  function automatic ramp_tab_t open_tab_f();
    ramp_tab_t t;
    for (int unsigned i = 0; i < TAB_DEPTH; i++) begin
      t[i] = '0;
      if (i >= 1 && i <= OPEN_STEPS) begin
        t[i] = level_t'(CLOSED_LEVEL - (CLOSED_LEVEL * i + OPEN_STEPS / 2) / OPEN_STEPS);
      end
    end
    return t;
  endfunction

  localparam ramp_tab_t CLOSE_TAB = close_tab_f();
  localparam ramp_tab_t OPEN_TAB  = open_tab_f();

  // microcode
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_NOP,
    OP_MUL,
    OP_BOUND,
    OP_DIV,
    OP_TARGET,
    OP_EXEC
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_NO_DRAW,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  last;
  } ucode_t;

  localparam upc_t UA_FETCH  = 3'd0;
  localparam upc_t UA_CHECK  = 3'd1;
  localparam upc_t UA_MUL    = 3'd2;
  localparam upc_t UA_BOUND  = 3'd3;
  localparam upc_t UA_DIV    = 3'd4;
  localparam upc_t UA_TARGET = 3'd5;
  localparam upc_t UA_EXEC   = 3'd6;

  // taken jump goes to target, else last returns to fetch, else fall through
  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    case (a)
      UA_FETCH:  w = '{op: OP_ACCEPT, cond: C_NO_INPUT, target: UA_FETCH,  last: 1'b0};
      UA_CHECK:  w = '{op: OP_NOP,    cond: C_NO_DRAW,  target: UA_EXEC,   last: 1'b0};
      UA_MUL:    w = '{op: OP_MUL,    cond: C_NEVER,    target: UA_FETCH,  last: 1'b0};
      UA_BOUND:  w = '{op: OP_BOUND,  cond: C_NEVER,    target: UA_FETCH,  last: 1'b0};
      UA_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE, target: UA_DIV,    last: 1'b0};
      UA_TARGET: w = '{op: OP_TARGET, cond: C_NEVER,    target: UA_FETCH,  last: 1'b0};
      UA_EXEC:   w = '{op: OP_EXEC,   cond: C_OUT_BUSY, target: UA_EXEC,   last: 1'b1};
      default:   w = '{op: OP_NOP,    cond: C_NEVER,    target: UA_FETCH,  last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/randomized_blink_envelope_sequencer_core.sv
// Steps: fetch, check and exec; an item that draws a new wait runs mul, bound, div and target
//   before exec, and exec waits while the output is stalled. One item at a time; the draw
//   cost is set by the 32-step restoring remainder loop (one bit of random_word per cycle).
// Input is taken only at the fetch step; a result waiting in the output register does not
//   block the next fetch.
// Reset: rst (synchronous) restores config, sequencer state and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
// Randomized blink envelope sequencer
// Microcoded sequencer: draws idle waits and runs the close/hold/open eyelid ramp.
// ----------------------------------------------------------------------------
`include "randomized_blink_envelope_sequencer_core_defines.svh"

module randomized_blink_envelope_sequencer_core
  import rbes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  // configuration
  logic [8:0]  energy;
  ival_t       min_interval;
  ival_t       max_interval;
  logic [11:0] bias;

  // sequencer
  upc_t   upc;
  upc_t   upc_next;
  ucode_t cw;
  logic   cond_hit;
  logic   out_busy;
  logic   exec_fire;

  // datapath
  cmd_t        cmd;
  logic [31:0] rw_sh;
  logic [20:0] prod_lo;
  logic [20:0] prod_hi;
  ival_t       lo;
  logic [13:0] span;
  ival_t       rem;
  logic [4:0]  div_cnt;
  logic [8:0]  e_sat;
  logic [13:0] lo_raw;
  ival_t       adj;
  ival_t       hi;
  ival_t       lo_clamp;
  logic [13:0] partial;
  logic [13:0] diff;

  blk_t blk;
  blk_t blk_next;
  logic wrote;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      energy       <= 9'd128;
      min_interval <= 13'd2500;
      max_interval <= 13'd5000;
      bias         <= 12'd600;
    end else if (cfg_wr_en) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_ENERGY:  energy       <= cfg_data[8:0];
        CFG_MIN_IVL: min_interval <= cfg_data;
        CFG_MAX_IVL: max_interval <= cfg_data;
        CFG_BIAS:    bias         <= cfg_data[11:0];
        default:     ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  assign cw        = ucode_rom(upc);
  assign out_busy  = out_valid && out_stall;
  assign exec_fire = (cw.op == OP_EXEC) && !out_busy;
  assign in_stall  = (upc != UA_FETCH);

  always_comb begin
    case (cw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_NO_INPUT: cond_hit = !in_valid;
      C_NO_DRAW:  cond_hit = !((blk.phase == PH_WAIT) && blk.need_draw);
      C_DIV_MORE: cond_hit = (div_cnt != 5'd0);
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      upc_next = cw.target;
    end else if (cw.last) begin
      upc_next = UA_FETCH;
    end else begin
      upc_next = upc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // ---------------------------------------------------------- wait bounds
  assign e_sat    = (energy > 9'd256) ? 9'd256 : energy;
  assign lo_raw   = {1'b0, min_interval} + {1'b0, prod_lo[20:8]};
  assign adj      = prod_hi[20:8];
  assign hi       = (max_interval >= adj) ? (max_interval - adj) : '0;
  assign lo_clamp = (lo_raw > {1'b0, hi}) ? hi : lo_raw[12:0];

  // restoring remainder, one bit of random_word per step
  assign partial = {rem, rw_sh[31]};
  assign diff    = partial - span;

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          cmd   <= cmd_t'(in_data.command);
          rw_sh <= in_data.random_word;
        end
      end
      OP_MUL: begin
        prod_lo <= {12'd0, 9'd256 - e_sat} * {9'd0, bias};
        prod_hi <= {12'd0, e_sat} * {9'd0, bias};
      end
      OP_BOUND: begin
        lo      <= lo_clamp;
        span    <= {1'b0, hi} - {1'b0, lo_clamp} + 14'd1;
        rem     <= '0;
        div_cnt <= 5'd31;
      end
      OP_DIV: begin
        rem     <= (partial >= span) ? diff[12:0] : partial[12:0];
        rw_sh   <= {rw_sh[30:0], 1'b0};
        div_cnt <= div_cnt - 5'd1;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------- blink control
  function automatic blk_t f_hold(blk_t s);
    blk_t r;
    r       = s;
    r.phase = PH_HOLD;
    r.tick  = '0;
    r.level = level_t'(CLOSED_LEVEL);
    return r;
  endfunction

  function automatic blk_t f_start(blk_t s);
    blk_t r;
    r      = s;
    r.tick = '0;
    if (CLOSE_STEPS == 0) begin
      r = f_hold(r);
    end else begin
      r.phase = PH_CLOSE;
      r.step  = step_t'(1);
      r.level = CLOSE_TAB[1];
    end
    return r;
  endfunction

  function automatic blk_t f_finish(blk_t s);
    blk_t r;
    r       = s;
    r.level = '0;
    r.tick  = '0;
    r.step  = '0;
    if (r.pend) begin
      r.pend = 1'b0;
      r      = f_start(r);
    end else begin
      r.phase      = PH_WAIT;
      r.need_draw  = 1'b1;
      r.wait_count = '0;
    end
    return r;
  endfunction

  function automatic blk_t f_open(blk_t s);
    blk_t r;
    r      = s;
    r.tick = '0;
    if (OPEN_STEPS == 0) begin
      r = f_finish(r);
    end else begin
      r.phase = PH_OPEN;
      r.step  = step_t'(1);
      r.level = OPEN_TAB[1];
    end
    return r;
  endfunction

  always_comb begin
    logic [TICK_W:0] tick_inc;
    blk_next = blk;
    wrote    = 1'b0;
    tick_inc = {1'b0, blk.tick} + (TICK_W + 1)'(1);
    case (cmd)
      CMD_TICK: begin
        case (blk.phase)
          PH_WAIT: begin
            if ({1'b0, blk.wait_count} + 14'd1 >= {1'b0, blk.wait_target}) begin
              if (blk.sup) begin
                blk_next.need_draw = 1'b1;
              end else begin
                blk_next = f_start(blk);
                wrote    = 1'b1;
              end
            end else begin
              blk_next.wait_count = blk.wait_count + 13'd1;
            end
          end
          PH_CLOSE: begin
            blk_next.tick = tick_inc[TICK_W-1:0];
            if (tick_inc >= (TICK_W + 1)'(STEP_TICKS)) begin
              blk_next.tick = '0;
              wrote         = 1'b1;
              if (blk.step < step_t'(CLOSE_STEPS)) begin
                blk_next.step  = blk.step + step_t'(1);
                blk_next.level = CLOSE_TAB[blk.step + step_t'(1)];
              end else begin
                blk_next = f_hold(blk_next);
              end
            end
          end
          PH_HOLD: begin
            blk_next.tick = tick_inc[TICK_W-1:0];
            if (tick_inc >= (TICK_W + 1)'(HOLD_TICKS)) begin
              blk_next = f_open(blk_next);
              wrote    = 1'b1;
            end
          end
          default: begin
            blk_next.tick = tick_inc[TICK_W-1:0];
            if (tick_inc >= (TICK_W + 1)'(STEP_TICKS)) begin
              blk_next.tick = '0;
              wrote         = 1'b1;
              if (blk.step < step_t'(OPEN_STEPS)) begin
                blk_next.step  = blk.step + step_t'(1);
                blk_next.level = OPEN_TAB[blk.step + step_t'(1)];
              end else begin
                blk_next = f_finish(blk_next);
              end
            end
          end
        endcase
      end
      CMD_TRIGGER: begin
        if (blk.phase == PH_WAIT) begin
          if (blk.sup) begin
            blk_next.need_draw = 1'b1;
          end else begin
            blk_next = f_start(blk);
            wrote    = 1'b1;
          end
        end else begin
          blk_next.pend = 1'b1;
        end
      end
      CMD_SUP_ON: begin
        blk_next.sup       = 1'b1;
        blk_next.level     = '0;
        blk_next.phase     = PH_WAIT;
        blk_next.pend      = 1'b0;
        blk_next.tick      = '0;
        blk_next.step      = '0;
        blk_next.need_draw = 1'b1;
        wrote              = 1'b1;
      end
      default: begin
        blk_next.sup   = 1'b0;
        blk_next.level = '0;
        wrote          = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk.phase       <= PH_WAIT;
      blk.wait_count  <= '0;
      blk.wait_target <= '0;
      blk.need_draw   <= 1'b1;
      blk.tick        <= '0;
      blk.step        <= '0;
      blk.pend        <= 1'b0;
      blk.sup         <= 1'b0;
      blk.level       <= '0;
    end else if (cw.op == OP_TARGET) begin
      blk.wait_target <= lo + rem;
      blk.wait_count  <= '0;
      blk.need_draw   <= 1'b0;
    end else if (exec_fire) begin
      blk <= blk_next;
    end
  end

  // -------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data.blink_level   <= blk_next.level;
      out_data.level_changed <= wrote;
      out_data.phase         <= blk_next.phase;
    end
  end

  // ---------------------------------------------------------- assertions
  `RBES_ASSERT_IMP(a_span_nonzero, cw.op == OP_DIV, span != 14'd0, "zero span in remainder loop")
  `RBES_ASSERT_IMP(a_rem_below_span, cw.op == OP_DIV, {1'b0, rem} < span, "remainder not below span")
  `RBES_ASSERT_NXT(a_exec_loads_out, exec_fire, out_valid, "result not presented after exec")
  `RBES_ASSERT_IMP(a_level_range, 1'b1, blk.level <= level_t'(CLOSED_LEVEL), "level above closed")

endmodule

FILE: dv/tb_randomized_blink_envelope_sequencer_core.sv
// ----------------------------------------------------------------------------
// Blink envelope sequencer testbench
// Drives tick, trigger and suppress transactions into the sequencer and checks
// every result against an in-bench model of the wait draw and eyelid ramps.
// Runs directed corner cases, then random traffic under several register
// settings and idle patterns, plus a long output hold-off.
// ----------------------------------------------------------------------------
module tb_randomized_blink_envelope_sequencer_core;
  import rbes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTS   = 50;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  cfg_addr_t  cfg_addr;
  logic [12:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  randomized_blink_envelope_sequencer_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // model of the sequencer
  int unsigned reg_energy, reg_min, reg_max, reg_bias;
  phase_t      lid_phase;
  int unsigned lid_wait_cnt, lid_wait_tgt, lid_tick, lid_step;
  bit          lid_need_draw, lid_queued, lid_muted, lid_wrote;
  level_t      lid_level;

  out_item_t   envelope_q[$];
  out_item_t   due;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 0;
  int unsigned blinks_started, blinks_done, blinks_cut;

  function automatic int unsigned close_level(int unsigned i);
    return (CLOSE_TARGET * i + CLOSE_STEPS / 2) / CLOSE_STEPS;
  endfunction

  function automatic int unsigned open_level(int unsigned i);
    return CLOSED_LEVEL - (CLOSED_LEVEL * i + OPEN_STEPS / 2) / OPEN_STEPS;
  endfunction

  function automatic void put_level(int unsigned v);
    lid_level = level_t'(v & 'h1FF);
    lid_wrote = 1'b1;
  endfunction

  function automatic void enter_hold();
    lid_phase = PH_HOLD;
    lid_tick  = 0;
    put_level(CLOSED_LEVEL);
  endfunction

  function automatic void start_blink();
    lid_tick = 0;
    blinks_started++;
    if (CLOSE_STEPS == 0) begin
      put_level(CLOSE_TARGET);
      enter_hold();
    end else begin
      lid_phase = PH_CLOSE;
      lid_step  = 1;
      put_level(close_level(1));
    end
  endfunction

  function automatic void end_blink();
    put_level(0);
    lid_tick = 0;
    lid_step = 0;
    blinks_done++;
    if (lid_queued) begin
      lid_queued = 1'b0;
      start_blink();
    end else begin
      lid_phase     = PH_WAIT;
      lid_need_draw = 1'b1;
      lid_wait_cnt  = 0;
    end
  endfunction

  function automatic out_item_t predict_envelope(in_item_t it);
    int unsigned e, lo, hi, adj;
    out_item_t   r;
    lid_wrote = 1'b0;
    if (lid_phase == PH_WAIT && lid_need_draw) begin
      e   = (reg_energy > 256) ? 256 : reg_energy;
      lo  = reg_min + (((256 - e) * reg_bias) >> 8);
      adj = (e * reg_bias) >> 8;
      hi  = (reg_max >= adj) ? reg_max - adj : 0;
      if (lo > hi) lo = hi;
      lid_wait_tgt  = (lo + it.random_word % (hi - lo + 1)) & 'h1FFF;
      lid_wait_cnt  = 0;
      lid_need_draw = 1'b0;
    end
    case (cmd_t'(it.command))
      CMD_TICK: begin
        case (lid_phase)
          PH_WAIT: begin
            if (lid_wait_cnt + 1 >= lid_wait_tgt) begin
              if (lid_muted) lid_need_draw = 1'b1;
              else start_blink();
            end else begin
              lid_wait_cnt++;
            end
          end
          PH_CLOSE: begin
            lid_tick++;
            if (lid_tick >= STEP_TICKS) begin
              lid_tick = 0;
              if (lid_step < CLOSE_STEPS) begin
                lid_step++;
                put_level(close_level(lid_step));
              end else begin
                enter_hold();
              end
            end
          end
          PH_HOLD: begin
            lid_tick++;
            if (lid_tick >= HOLD_TICKS) begin
              lid_tick = 0;
              if (OPEN_STEPS == 0) begin
                end_blink();
              end else begin
                lid_phase = PH_OPEN;
                lid_step  = 1;
                put_level(open_level(1));
              end
            end
          end
          default: begin
            lid_tick++;
            if (lid_tick >= STEP_TICKS) begin
              lid_tick = 0;
              if (lid_step < OPEN_STEPS) begin
                lid_step++;
                put_level(open_level(lid_step));
              end else begin
                end_blink();
              end
            end
          end
        endcase
      end
      CMD_TRIGGER: begin
        if (lid_phase == PH_WAIT) begin
          if (lid_muted) lid_need_draw = 1'b1;
          else start_blink();
        end else begin
          lid_queued = 1'b1;
        end
      end
      CMD_SUP_ON: begin
        if (lid_phase != PH_WAIT) blinks_cut++;
        lid_muted = 1'b1;
        put_level(0);
        lid_phase     = PH_WAIT;
        lid_queued    = 1'b0;
        lid_tick      = 0;
        lid_step      = 0;
        lid_need_draw = 1'b1;
      end
      default: begin
        lid_muted = 1'b0;
        put_level(0);
      end
    endcase
    r.blink_level   = lid_level;
    r.level_changed = lid_wrote;
    r.phase         = lid_phase;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH %0d at result %0d: %s got %0d expected %0d",
               mismatches, results_seen, what, got, want);
  endtask

  // one process checks results first, then predicts the accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (envelope_q.size() == 0) begin
          report_mismatch("unexpected result, level", out_data.blink_level, 0);
        end else begin
          due = envelope_q.pop_front();
          if (out_data.blink_level !== due.blink_level)
            report_mismatch("blink_level", out_data.blink_level, due.blink_level);
          if (out_data.level_changed !== due.level_changed)
            report_mismatch("level_changed", out_data.level_changed, due.level_changed);
          if (out_data.phase !== due.phase)
            report_mismatch("phase", out_data.phase, due.phase);
        end
      end
      if (in_valid && !in_stall) envelope_q.push_back(predict_envelope(in_data));
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, envelope_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [31:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, random_word: word};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (envelope_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_addr_t a, input int unsigned v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_data  <= 13'(v);
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned e, input int unsigned mn,
                            input int unsigned mx, input int unsigned b);
    wait_idle();
    write_reg(CFG_ENERGY, e);
    write_reg(CFG_MIN_IVL, mn);
    write_reg(CFG_MAX_IVL, mx);
    write_reg(CFG_BIAS, b);
    cfg_wr_en  <= 1'b0;
    reg_energy = e & 'h1FF;
    reg_min    = mn & 'h1FFF;
    reg_max    = mx & 'h1FFF;
    reg_bias   = b & 'hFFF;
    settings_used++;
  endtask

  // mostly clean tick runs with triggers so blinks complete; short noisy bursts
  task automatic run_traffic(input int unsigned count);
    int unsigned left, burst, pick;
    bit          noisy;
    left = count;
    while (left != 0) begin
      noisy = ($urandom_range(2) == 0);
      burst = noisy ? $urandom_range(2, 10) : $urandom_range(30, 300);
      if (burst > left) burst = left;
      repeat (burst) begin
        pick = $urandom_range(99);
        if (noisy) send_item(cmd_t'($urandom_range(3)), $urandom);
        else if (pick < 92) send_item(CMD_TICK, $urandom);
        else if (pick < 98) send_item(CMD_TRIGGER, $urandom);
        else send_item(CMD_SUP_OFF, $urandom);
      end
      left -= burst;
    end
  endtask

  task automatic test_reset_defaults();
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    send_item(CMD_TICK, 32'h0000_0000);
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    send_item(CMD_TRIGGER, $urandom);
    send_item(CMD_TRIGGER, $urandom);   // queued behind the running blink
    send_item(CMD_TRIGGER, $urandom);   // merges with the queued one
    send_item(CMD_SUP_ON, $urandom);
    send_item(CMD_SUP_ON, $urandom);
    send_item(CMD_TRIGGER, $urandom);   // suppressed, only redraws
    send_item(CMD_SUP_OFF, $urandom);
    send_item(CMD_TICK, $urandom);
  endtask

  task automatic test_corner_config();
    set_config(0, 0, 0, 0);             // zero wait range, takes effect at the next draw
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    send_item(CMD_SUP_OFF, $urandom);
    send_item(CMD_TICK, $urandom);
    send_item(CMD_SUP_ON, $urandom);
    send_item(CMD_TICK, $urandom);      // wait ends while suppressed
    send_item(CMD_TICK, $urandom);
    send_item(CMD_SUP_OFF, $urandom);
    // energy above 256 with junk upper bits, max saturates, lo clamps down
    set_config(13'h1F80, 8191, 0, 4095);
    send_item(CMD_TICK, $urandom);
    send_item(CMD_TRIGGER, $urandom);
    // lo above hi clamps to the top of the range
    set_config(0, 8191, 8191, 4095);
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    send_item(CMD_TRIGGER, 32'h0000_0000);
    send_item(CMD_TICK, $urandom);
  endtask

  task automatic test_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_config(128, 0, 40, 0);
    run_traffic(125);
    set_config(256, 0, 100, 4095);
    run_traffic(125);
  endtask

  task automatic test_sender_sparse();
    src_idle_pct   = 82;
    sink_stall_pct = 0;
    set_config(0, 10, 60, 30);
    run_traffic(125);
    set_config(200, 30, 20, 8);
    run_traffic(125);
  endtask

  task automatic test_receiver_stalled();
    src_idle_pct   = 0;
    sink_stall_pct = 82;
    repeat (2) begin
      set_config($urandom_range(511), $urandom_range(50), $urandom_range(120),
                 $urandom_range(200));
      run_traffic(125);
    end
  endtask

  task automatic test_mixed_idle();
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    set_config(128, 2500, 5000, 600);
    run_traffic(125);
    set_config(511, 8191, 8191, 0);
    run_traffic(125);
  endtask

  // receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 50;
    set_config(64, 0, 30, 100);
    hold_left <= 500;
    run_traffic(40);
    wait_idle();
    run_traffic(20);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_ENERGY;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    reg_energy     = 128;
    reg_min        = 2500;
    reg_max        = 5000;
    reg_bias       = 600;
    lid_phase      = PH_WAIT;
    lid_wait_cnt   = 0;
    lid_wait_tgt   = 0;
    lid_need_draw  = 1'b1;
    lid_tick       = 0;
    lid_step       = 0;
    lid_queued     = 1'b0;
    lid_muted      = 1'b0;
    lid_wrote      = 1'b0;
    lid_level      = '0;
    blinks_started = 0;
    blinks_done    = 0;
    blinks_cut     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_corner_config();
    test_no_idle();
    test_sender_sparse();
    test_receiver_stalled();
    test_mixed_idle();
    test_backpressure();
    wait_idle();

    $display("Covered %0d transactions, %0d results, %0d register settings",
             items_sent, results_seen, settings_used);
    $display("Blinks started %0d, completed %0d, cut by suppress %0d; mismatches %0d",
             blinks_started, blinks_done, blinks_cut, mismatches);
    if (mismatches == 0 && envelope_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: randomized_blink_envelope_sequencer_core.f
+incdir+hw/rtl
hw/rtl/rbes_pkg.sv
hw/rtl/randomized_blink_envelope_sequencer_core.sv
dv/tb_randomized_blink_envelope_sequencer_core.sv
